>>> design/sat_pkg.sv
package sat_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CH_WIDTH    = 8;
    localparam int IDX_WIDTH   = 4;

    localparam logic [CH_WIDTH-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_WIDTH-1:0] CH_LOW_A   = 8'h61;
    localparam logic [CH_WIDTH-1:0] CH_LOW_F   = 8'h66;
    localparam logic [CH_WIDTH-1:0] CH_UP_A    = 8'h41;
    localparam logic [CH_WIDTH-1:0] CH_UP_F    = 8'h46;
    localparam logic [CH_WIDTH-1:0] CH_LOW_X   = 8'h78;
    localparam logic [CH_WIDTH-1:0] CH_UP_X    = 8'h58;

    localparam logic [IDX_WIDTH-1:0] MAX_TOKENS_RESET = 4'd4;

    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_STRING = 1'b1;

    typedef enum logic [1:0] {
        MODE_DEC = 2'd0,
        MODE_HEX = 2'd1,
        MODE_STR = 2'd2
    } t_mode;

    typedef struct packed {
        logic                   in_token;
        t_mode                  mode;
        logic                   after_zero;
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_WIDTH-1:0]   counter;
        logic                   overflowed;
    } t_line_state;

    typedef struct packed {
        logic                   token_valid;
        logic                   token_kind;
        logic [VALUE_WIDTH-1:0] token_value;
        logic [IDX_WIDTH-1:0]   token_index;
        logic                   line_done;
        logic [IDX_WIDTH-1:0]   token_count;
        logic                   too_many;
    } t_result;

    localparam t_line_state LINE_CLEAR = '{
        in_token:   1'b0,
        mode:       MODE_DEC,
        after_zero: 1'b0,
        value:      '0,
        counter:    '0,
        overflowed: 1'b0
    };

endpackage

>>> design/sat_next.sv
module sat_next (
    input  sat_pkg::t_line_state          i_state,
    input  logic [sat_pkg::CH_WIDTH-1:0]  i_ch,
    input  logic [sat_pkg::IDX_WIDTH-1:0] i_max_tokens,
    output sat_pkg::t_line_state          o_state,
    output logic                          o_has_result,
    output sat_pkg::t_result              o_result
);
    import sat_pkg::*;

    logic                   is_dec;
    logic                   is_hex_alpha;
    logic [3:0]             hex_digit;
    logic [VALUE_WIDTH-1:0] dec_value;
    logic [VALUE_WIDTH-1:0] hex_value;
    logic                   emit;

    assign is_dec       = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_hex_alpha = ((i_ch >= CH_LOW_A) && (i_ch <= CH_LOW_F))
                       || ((i_ch >= CH_UP_A) && (i_ch <= CH_UP_F));
    assign hex_digit    = is_dec ? i_ch[3:0] : (i_ch[3:0] + 4'd9);

    assign dec_value = {i_state.value[VALUE_WIDTH-4:0], 3'b000}
                     + {i_state.value[VALUE_WIDTH-2:0], 1'b0}
                     + {{(VALUE_WIDTH-4){1'b0}}, i_ch[3:0]};
    assign hex_value = {i_state.value[VALUE_WIDTH-5:0], hex_digit};

    assign emit = i_state.in_token && !i_state.overflowed
               && ((i_ch == CH_NUL) || (i_ch == CH_SPACE));

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;

        if (emit) begin
            o_result.token_valid = 1'b1;
            o_result.token_kind  = (i_state.mode == MODE_STR) ? KIND_STRING : KIND_NUMBER;
            o_result.token_value = i_state.value;
            o_result.token_index = i_state.counter;
        end

        if (i_ch == CH_NUL) begin
            o_has_result         = 1'b1;
            o_result.line_done   = 1'b1;
            o_result.too_many    = i_state.overflowed;
            if (!i_state.overflowed) begin
                o_result.token_count = emit ? (i_state.counter + 4'd1) : i_state.counter;
            end
            o_state = LINE_CLEAR;
        end else if (i_state.overflowed) begin
            o_state = i_state;
        end else if (i_ch == CH_SPACE) begin
            if (emit) begin
                o_has_result       = 1'b1;
                o_state.in_token   = 1'b0;
                o_state.mode       = MODE_DEC;
                o_state.after_zero = 1'b0;
                o_state.value      = '0;
                o_state.counter    = i_state.counter + 4'd1;
            end
        end else if (!i_state.in_token) begin
            if (i_state.counter >= i_max_tokens) begin
                o_state.overflowed = 1'b1;
            end else begin
                o_state.in_token   = 1'b1;
                o_state.after_zero = (i_ch == CH_ZERO);
                o_state.mode       = is_dec ? MODE_DEC : MODE_STR;
                o_state.value      = is_dec ? {{(VALUE_WIDTH-4){1'b0}}, i_ch[3:0]} : '0;
            end
        end else if (i_state.after_zero && ((i_ch == CH_LOW_X) || (i_ch == CH_UP_X))) begin
            o_state.after_zero = 1'b0;
            o_state.mode       = MODE_HEX;
        end else begin
            o_state.after_zero = 1'b0;
            case (i_state.mode)
                MODE_DEC: begin
                    if (is_dec) begin
                        o_state.value = dec_value;
                    end else begin
                        o_state.mode = MODE_STR;
                    end
                end
                MODE_HEX: begin
                    if (is_dec || is_hex_alpha) begin
                        o_state.value = hex_value;
                    end else begin
                        o_state.mode = MODE_STR;
                    end
                end
                default: begin
                    o_state.mode = MODE_STR;
                end
            endcase
        end
    end

endmodule

>>> design/shell_argument_tokenizer.sv
// Channel   Direction  Handshake                        Payload
// input     in         i_ch_valid / o_ch_ready          i_ch
// result    out        o_res_valid / i_res_ready        o_token_* o_line_done o_token_count
//                                                       o_too_many
// config    in         i_cfg_valid / o_cfg_ready        i_cfg_max_tokens
//
// One character item is taken per cycle; its result, if any, is in the output register
// on the next cycle. The rate is set by the single decimal or hex accumulate step.
// Input is stalled only while a result waits in the output register and is not taken.
// Synchronous active-low reset clears the line state, empties the output register and
// sets max_tokens to 4. Configuration writes are always taken.
module shell_argument_tokenizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ch_valid,
    output logic                                o_ch_ready,
    input  logic [sat_pkg::CH_WIDTH-1:0]        i_ch,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_token_valid,
    output logic                                o_token_kind,
    output logic [sat_pkg::VALUE_WIDTH-1:0]     o_token_value,
    output logic [sat_pkg::IDX_WIDTH-1:0]       o_token_index,
    output logic                                o_line_done,
    output logic [sat_pkg::IDX_WIDTH-1:0]       o_token_count,
    output logic                                o_too_many,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sat_pkg::IDX_WIDTH-1:0]       i_cfg_max_tokens
);
    import sat_pkg::*;

    t_line_state          r_state;
    t_line_state          n_state;
    t_result              r_result;
    t_result              n_result;
    logic                 r_res_valid;
    logic [IDX_WIDTH-1:0] r_max_tokens;
    logic                 has_result;
    logic                 ch_accept;

    assign o_ch_ready  = !r_res_valid || i_res_ready;
    assign o_cfg_ready = 1'b1;
    assign ch_accept   = i_ch_valid && o_ch_ready;

    sat_next u_next (
        .i_state      (r_state),
        .i_ch         (i_ch),
        .i_max_tokens (r_max_tokens),
        .o_state      (n_state),
        .o_has_result (has_result),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= LINE_CLEAR;
            r_res_valid  <= 1'b0;
            r_max_tokens <= MAX_TOKENS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_max_tokens <= i_cfg_max_tokens;
            end
            if (ch_accept) begin
                r_state     <= n_state;
                r_res_valid <= has_result;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ch_accept && has_result) begin
            r_result <= n_result;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_token_valid = r_result.token_valid;
    assign o_token_kind  = r_result.token_kind;
    assign o_token_value = r_result.token_value;
    assign o_token_index = r_result.token_index;
    assign o_line_done   = r_result.line_done;
    assign o_token_count = r_result.token_count;
    assign o_too_many    = r_result.too_many;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(r_result)))
        else $error("Result changed while stalled.");

    a_too_many_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_too_many) |-> (o_line_done && !o_token_valid
                                         && (o_token_count == '0)))
        else $error("Cut line result has a token or a count.");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_token_valid) |-> (o_token_index != {IDX_WIDTH{1'b1}}))
        else $error("Token index beyond the largest limit.");

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ch_accept && (i_ch == CH_NUL)) |=> (!r_state.in_token && !r_state.overflowed
                                             && (r_state.counter == '0)
                                             && o_res_valid && o_line_done))
        else $error("Line end did not clear the line state.");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import sat_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 3;
    localparam int MAX_REPORTS    = 40;

    localparam logic [IDX_WIDTH-1:0] PHASE_LIMITS [PHASES] = '{
        4'd15, 4'd1, 4'd0, 4'd2, 4'd9, 4'd12, 4'd7, 4'd4
    };

    typedef enum int {
        GEN_DEC,
        GEN_ZERO_DEC,
        GEN_HEX,
        GEN_STR,
        GEN_BROKEN
    } t_gen_kind;

    typedef struct {
        logic [CH_WIDTH-1:0] ch;
        bit                  typed;
        t_result             res;
    } t_stim_row;

    // Default limit of four tokens applies to this whole part.
    t_stim_row stim_rows [21] = '{
        '{CH_NUL,   1'b1, '{1'b0, KIND_NUMBER, 32'd0, 4'd0, 1'b1, 4'd0, 1'b0}},
        '{CH_ZERO,  1'b0, '0},
        '{CH_LOW_X, 1'b0, '0},
        '{CH_NUL,   1'b1, '{1'b1, KIND_NUMBER, 32'd0, 4'd0, 1'b1, 4'd1, 1'b0}},
        '{CH_NINE,  1'b0, '0},
        '{CH_NINE,  1'b0, '0},
        '{CH_SPACE, 1'b1, '{1'b1, KIND_NUMBER, 32'd99, 4'd0, 1'b0, 4'd0, 1'b0}},
        '{CH_ZERO,  1'b0, '0},
        '{CH_UP_X,  1'b0, '0},
        '{CH_UP_F,  1'b0, '0},
        '{CH_LOW_F, 1'b0, '0},
        '{CH_SPACE, 1'b1, '{1'b1, KIND_NUMBER, 32'd255, 4'd1, 1'b0, 4'd0, 1'b0}},
        '{8'hFF,    1'b0, '0},
        '{8'h80,    1'b0, '0},
        '{CH_SPACE, 1'b1, '{1'b1, KIND_STRING, 32'd0, 4'd2, 1'b0, 4'd0, 1'b0}},
        '{CH_ZERO,  1'b0, '0},
        '{"5",      1'b0, '0},
        '{CH_SPACE, 1'b0, '0},
        '{"7",      1'b0, '0},
        '{"a",      1'b0, '0},
        '{CH_NUL,   1'b1, '{1'b0, KIND_NUMBER, 32'd0, 4'd0, 1'b1, 4'd0, 1'b1}}
    };

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_ch_valid       = 1'b0;
    logic [CH_WIDTH-1:0]    i_ch             = '0;
    logic                   i_res_ready      = 1'b0;
    logic                   i_cfg_valid      = 1'b0;
    logic [IDX_WIDTH-1:0]   i_cfg_max_tokens = '0;
    logic                   o_ch_ready;
    logic                   o_res_valid;
    logic                   o_token_valid;
    logic                   o_token_kind;
    logic [VALUE_WIDTH-1:0] o_token_value;
    logic [IDX_WIDTH-1:0]   o_token_index;
    logic                   o_line_done;
    logic [IDX_WIDTH-1:0]   o_token_count;
    logic                   o_too_many;
    logic                   o_cfg_ready;

    bit                     tok_open;
    t_mode                  tok_mode;
    bit                     lead_zero;
    logic [VALUE_WIDTH-1:0] acc;
    logic [IDX_WIDTH-1:0]   tok_cnt;
    bit                     cut;
    logic [IDX_WIDTH-1:0]   max_tok;

    t_result             token_q [$];
    t_result             want_res;
    logic [CH_WIDTH-1:0] line_buf [$];
    int                  errors      = 0;
    bit                  quiet       = 1'b0;
    int                  stall_left  = 0;
    int                  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    shell_argument_tokenizer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ch_valid       (i_ch_valid),
        .o_ch_ready       (o_ch_ready),
        .i_ch             (i_ch),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_token_valid    (o_token_valid),
        .o_token_kind     (o_token_kind),
        .o_token_value    (o_token_value),
        .o_token_index    (o_token_index),
        .o_line_done      (o_line_done),
        .o_token_count    (o_token_count),
        .o_too_many       (o_too_many),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_max_tokens (i_cfg_max_tokens)
    );

    function automatic void clear_line();
        tok_open  = 1'b0;
        tok_mode  = MODE_DEC;
        lead_zero = 1'b0;
        acc       = '0;
        tok_cnt   = '0;
        cut       = 1'b0;
    endfunction

    function automatic void take_char(logic [CH_WIDTH-1:0] c);
        logic [CH_WIDTH-1:0] d;
        if (tok_mode == MODE_DEC) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
            end else begin
                tok_mode = MODE_STR;
            end
        end else if (tok_mode == MODE_HEX) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
                d = c - CH_LOW_A + 8'd10;
            end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                d = c - CH_UP_A + 8'd10;
            end else begin
                tok_mode = MODE_STR;
                return;
            end
            acc = {acc[VALUE_WIDTH-5:0], d[3:0]};
        end
    endfunction

    function automatic void close_token(inout t_result r);
        r.token_valid = 1'b1;
        r.token_kind  = (tok_mode == MODE_STR) ? KIND_STRING : KIND_NUMBER;
        r.token_value = acc;
        r.token_index = tok_cnt;
        tok_cnt       = tok_cnt + 1'b1;
        tok_open      = 1'b0;
        tok_mode      = MODE_DEC;
        lead_zero     = 1'b0;
        acc           = '0;
    endfunction

    // Advances the line state by one character and tells whether it yields a result.
    function automatic bit predict_char(logic [CH_WIDTH-1:0] c, output t_result r);
        r = '0;
        if (c == CH_NUL) begin
            if (!cut && tok_open) begin
                close_token(r);
            end
            r.line_done   = 1'b1;
            r.too_many    = cut;
            r.token_count = cut ? '0 : tok_cnt;
            clear_line();
            return 1'b1;
        end
        if (cut) begin
            return 1'b0;
        end
        if (c == CH_SPACE) begin
            if (tok_open) begin
                close_token(r);
                return 1'b1;
            end
            return 1'b0;
        end
        if (!tok_open) begin
            if (tok_cnt >= max_tok) begin
                cut = 1'b1;
            end else begin
                tok_open  = 1'b1;
                acc       = '0;
                lead_zero = (c == CH_ZERO);
                tok_mode  = (c >= CH_ZERO && c <= CH_NINE) ? MODE_DEC : MODE_STR;
                take_char(c);
            end
        end else if (lead_zero && (c == CH_LOW_X || c == CH_UP_X)) begin
            lead_zero = 1'b0;
            tok_mode  = MODE_HEX;
        end else begin
            lead_zero = 1'b0;
            take_char(c);
        end
        return 1'b0;
    endfunction

    function automatic logic [CH_WIDTH-1:0] rand_digit();
        return CH_ZERO + CH_WIDTH'($urandom_range(0, 9));
    endfunction

    function automatic logic [CH_WIDTH-1:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return CH_ZERO + CH_WIDTH'(r);
        end else if (r < 16) begin
            return CH_LOW_A + CH_WIDTH'(r - 10);
        end
        return CH_UP_A + CH_WIDTH'(r - 16);
    endfunction

    function automatic logic [CH_WIDTH-1:0] rand_plain();
        logic [CH_WIDTH-1:0] c;
        do begin
            c = CH_WIDTH'($urandom_range(1, 255));
        end while (c == CH_SPACE);
        return c;
    endfunction

    function automatic void add_token(t_gen_kind kind);
        bit all_f;
        case (kind)
            GEN_DEC: begin
                line_buf.push_back(CH_ZERO + CH_WIDTH'($urandom_range(1, 9)));
                repeat ($urandom_range(0, ($urandom_range(0, 3) == 0) ? 14 : 4)) begin
                    line_buf.push_back(rand_digit());
                end
            end
            GEN_ZERO_DEC: begin
                line_buf.push_back(CH_ZERO);
                repeat ($urandom_range(0, 3)) line_buf.push_back(rand_digit());
            end
            GEN_HEX: begin
                all_f = ($urandom_range(0, 7) == 0);
                line_buf.push_back(CH_ZERO);
                line_buf.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
                if (all_f) begin
                    repeat ($urandom_range(8, 10)) begin
                        line_buf.push_back($urandom_range(0, 1) ? CH_LOW_F : CH_UP_F);
                    end
                end else begin
                    repeat ($urandom_range(0, ($urandom_range(0, 3) == 0) ? 12 : 6)) begin
                        line_buf.push_back(rand_hex());
                    end
                end
            end
            GEN_STR: begin
                repeat ($urandom_range(1, 6)) line_buf.push_back(rand_plain());
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    line_buf.push_back(CH_ZERO);
                    line_buf.push_back(CH_LOW_X);
                    repeat ($urandom_range(0, 4)) line_buf.push_back(rand_hex());
                end else begin
                    line_buf.push_back(rand_digit());
                    repeat ($urandom_range(0, 4)) line_buf.push_back(rand_digit());
                end
                line_buf.push_back(rand_plain());
                repeat ($urandom_range(0, 3)) line_buf.push_back(rand_digit());
            end
        endcase
    endfunction

    // Mostly well-formed lines with random tokens, with some raw byte noise in between.
    function automatic void build_line();
        int ntok;
        line_buf.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 20)) line_buf.push_back(CH_WIDTH'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                ntok = $urandom_range(0, int'(max_tok) + 2);
            end else begin
                ntok = $urandom_range(0, int'(max_tok));
            end
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) begin
                    repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
                end
                add_token(t_gen_kind'($urandom_range(GEN_DEC, GEN_BROKEN)));
            end
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
        end
        line_buf.push_back(CH_NUL);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        end
    endtask

    task automatic send_char(logic [CH_WIDTH-1:0] c, bit typed, t_result typed_res);
        t_result r;
        bit      has_res;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_ch_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_ch_valid <= 1'b1;
        i_ch       <= c;
        do @(posedge i_clk); while (!o_ch_ready);
        has_res = predict_char(c, r);
        if (typed) begin
            token_q.push_back(typed_res);
        end else if (has_res) begin
            token_q.push_back(r);
        end
    endtask

    task automatic settle();
        i_ch_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [IDX_WIDTH-1:0] v);
        settle();
        i_cfg_valid      <= 1'b1;
        i_cfg_max_tokens <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_tok = v;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (token_q.size() == 0) begin
                report("result with no item pending", 32'd1, 32'd0);
            end else begin
                want_res = token_q.pop_front();
                if (o_token_valid !== want_res.token_valid)
                    report("token_valid", 32'(o_token_valid), 32'(want_res.token_valid));
                if (o_token_kind !== want_res.token_kind)
                    report("token_kind", 32'(o_token_kind), 32'(want_res.token_kind));
                if (o_token_value !== want_res.token_value)
                    report("token_value", o_token_value, want_res.token_value);
                if (o_token_index !== want_res.token_index)
                    report("token_index", 32'(o_token_index), 32'(want_res.token_index));
                if (o_line_done !== want_res.line_done)
                    report("line_done", 32'(o_line_done), 32'(want_res.line_done));
                if (o_token_count !== want_res.token_count)
                    report("token_count", 32'(o_token_count), 32'(want_res.token_count));
                if (o_too_many !== want_res.too_many)
                    report("too_many", 32'(o_too_many), 32'(want_res.too_many));
            end
        end
        if (quiet) begin
            i_res_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_res_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_res_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_ch_valid && o_ch_ready) || (o_res_valid && i_res_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        logic [IDX_WIDTH-1:0] lim;
        clear_line();
        max_tok = MAX_TOKENS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (stim_rows[i]) begin
            send_char(stim_rows[i].ch, stim_rows[i].typed, stim_rows[i].res);
        end
        for (int p = 0; p < PHASES; p++) begin
            quiet = (p == PHASES - 1);
            lim = (p == 4 || p == 5) ? IDX_WIDTH'($urandom_range(0, 15)) : PHASE_LIMITS[p];
            write_limit(lim);
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                build_line();
                sent += line_buf.size();
                foreach (line_buf[k]) send_char(line_buf[k], 1'b0, '0);
            end
        end
        settle();
        if (token_q.size() != 0) begin
            report("results never seen", 32'd0, 32'(token_q.size()));
        end
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/sat_pkg.sv
design/sat_next.sv
design/shell_argument_tokenizer.sv
tb/tb.sv
